FILE: rtl/core/eop_pkg.sv
// Shared constants and functions for the ellipse outline point core.
// No dependencies.
`default_nettype none
package eop_pkg;

  localparam int AtanEntries = 24;
  localparam logic signed [33:0] CordicGainQ30 = 34'sd652032874;
  localparam logic signed [63:0] HalfRoundQ30 = 64'sd536870912;

  // Configuration register indexes
  localparam logic [2:0] CFG_CENTER_X  = 3'd0;
  localparam logic [2:0] CFG_CENTER_Y  = 3'd1;
  localparam logic [2:0] CFG_CENTER_Z  = 3'd2;
  localparam logic [2:0] CFG_MAJOR_LEN = 3'd3;
  localparam logic [2:0] CFG_MINOR_LEN = 3'd4;
  localparam logic [2:0] CFG_ROTATION  = 3'd5;
  localparam logic [2:0] CFG_PLANE_SEL = 3'd6;
  localparam logic [2:0] CFG_SEGMENTS  = 3'd7;

  // Plane select codes
  localparam logic [1:0] PLANE_XY = 2'd0;
  localparam logic [1:0] PLANE_YZ = 2'd1;
  localparam logic [1:0] PLANE_XZ = 2'd2;

  // Arctangent of 2^-k in 2^-32 turn units
  function automatic logic signed [33:0] atan_turn(input logic [4:0] k);
    logic signed [33:0] r;
    begin
      case (k)
        5'd0: r = 34'sd536870912;
        5'd1: r = 34'sd316933406;
        5'd2: r = 34'sd167458907;
        5'd3: r = 34'sd85004756;
        5'd4: r = 34'sd42667331;
        5'd5: r = 34'sd21354465;
        5'd6: r = 34'sd10679838;
        5'd7: r = 34'sd5340245;
        5'd8: r = 34'sd2670163;
        5'd9: r = 34'sd1335087;
        5'd10: r = 34'sd667544;
        5'd11: r = 34'sd333772;
        5'd12: r = 34'sd166886;
        5'd13: r = 34'sd83443;
        5'd14: r = 34'sd41722;
        5'd15: r = 34'sd20861;
        5'd16: r = 34'sd10430;
        5'd17: r = 34'sd5215;
        5'd18: r = 34'sd2608;
        5'd19: r = 34'sd1304;
        5'd20: r = 34'sd652;
        5'd21: r = 34'sd326;
        5'd22: r = 34'sd163;
        5'd23: r = 34'sd81;
        default: r = 34'sd0;
      endcase
      return r;
    end
  endfunction

  // Rounded Q30 product: (p + 2^29) >>> 30
  function automatic logic signed [33:0] rnd_q30(input logic signed [63:0] p);
    logic signed [63:0] t;
    begin
      t = (p + HalfRoundQ30) >>> 30;
      return t[33:0];
    end
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [35:0] v);
    begin
      if (v > 36'sh0_7FFF_FFFF) return 32'sh7FFF_FFFF;
      else if (v < -36'sh0_8000_0000) return 32'sh8000_0000;
      else return v[31:0];
    end
  endfunction

endpackage
`default_nettype wire

FILE: rtl/core/ellipse_outline_points_core.sv
// Top level: rotated ellipse outline point generator.
// Depends on eop_pkg, eop_div_cell, eop_cordic_cell.
// Stages: 17 divider cells + 1 reduce + CORDIC_STAGES cells
//   (at most AtanEntries) + 4 math stages + output register, accept to valid.
// Throughput: one point per cycle; the whole pipe advances when the output
//   register is empty or being taken. Reset (sync, active low) clears valids
//   and restores register defaults (segments = 1).
`default_nettype none
module ellipse_outline_points_core
  import eop_pkg::*;
#(
  parameter int MAX_SEGMENTS = 4096,
  parameter int CORDIC_STAGES = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [12:0] in_point_index,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [31:0]      out_pos_x,
  output logic [31:0]      out_pos_y,
  output logic [31:0]      out_pos_z,
  output logic [16:0]      out_tex_s,
  output logic [16:0]      out_tex_t,
  output logic             out_is_last,
  output logic             out_in_range,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [31:0] cfg_data
);
  localparam int NS = (CORDIC_STAGES < AtanEntries) ? CORDIC_STAGES : AtanEntries;
  localparam int DS = 17;
  localparam int NMath = 5;
  localparam int Depth = DS + 1 + NS + NMath;
  localparam int NumW = 30;

  // configuration registers
  logic signed [31:0] cx_r, cy_r, cz_r;
  logic [30:0] maj_r, min_r;
  logic [15:0] rot_r;
  logic [1:0]  pl_r;
  logic [12:0] seg_r;

  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cx_r <= '0; cy_r <= '0; cz_r <= '0; maj_r <= '0; min_r <= '0;
      rot_r <= '0; pl_r <= PLANE_XY; seg_r <= 13'd1;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_CENTER_X:  cx_r <= cfg_data;
        CFG_CENTER_Y:  cy_r <= cfg_data;
        CFG_CENTER_Z:  cz_r <= cfg_data;
        CFG_MAJOR_LEN: maj_r <= cfg_data[30:0];
        CFG_MINOR_LEN: min_r <= cfg_data[30:0];
        CFG_ROTATION:  rot_r <= cfg_data[15:0];
        CFG_PLANE_SEL: pl_r <= cfg_data[1:0];
        CFG_SEGMENTS:  seg_r <= cfg_data[12:0];
        default: ;
      endcase
    end
  end

  // effective segment count
  logic [12:0] seg_eff;
  always_comb begin
    if (seg_r == '0) seg_eff = 13'd1;
    else if (32'(seg_r) > 32'(MAX_SEGMENTS)) seg_eff = 13'(MAX_SEGMENTS);
    else seg_eff = seg_r;
  end

  // pipeline control: valid per stage, all stages move together
  logic [Depth-1:0] vld_r;
  logic adv;
  assign adv = !out_valid || out_ready;
  assign in_ready = adv;

  always_ff @(posedge clk) begin
    if (!rst_n) vld_r <= '0;
    else if (adv) vld_r <= {vld_r[Depth-2:0], in_valid};
  end

  // sideband carried along: in_range, is_last
  logic [1:0] side_r [Depth];
  always_ff @(posedge clk) begin
    if (adv) begin
      side_r[0] <= {(in_point_index <= seg_eff), (in_point_index == seg_eff)};
      for (int i = 1; i < Depth; i++) side_r[i] <= side_r[i-1];
    end
  end

  // divider chain
  logic [NumW-1:0] rem_w [DS+1];
  logic [12:0]     den_w [DS+1];
  logic [16:0]     q_w   [DS+1];
  assign rem_w[0] = {1'b0, in_point_index, 16'h0} & {NumW{in_point_index <= seg_eff}};
  assign den_w[0] = seg_eff;
  assign q_w[0]   = '0;

  for (genvar g = 0; g < DS; g++) begin : g_div
    eop_div_cell #(.NumW(NumW), .DenW(13), .BitPos(DS-1-g)) u_cell (
      .clk(clk), .adv(adv), .rem_i(rem_w[g]), .den_i(den_w[g]), .q_i(q_w[g]),
      .rem_o(rem_w[g+1]), .den_o(den_w[g+1]), .q_o(q_w[g+1])
    );
  end

  // angle reduction, registered
  logic signed [33:0] zu_r, zr_r;
  logic fu_r, fr_r;
  logic [16:0] u_r [NS+NMath+1];
  logic [31:0] au, ar, au2, ar2;
  logic fu, fr;
  always_comb begin
    au = {q_w[DS][15:0], 16'h0};
    ar = {rot_r, 16'h0};
    fu = (au >= 32'h4000_0000) && (au < 32'hC000_0000);
    fr = (ar >= 32'h4000_0000) && (ar < 32'hC000_0000);
    au2 = fu ? au - 32'h8000_0000 : au;
    ar2 = fr ? ar - 32'h8000_0000 : ar;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      zu_r <= 34'(signed'(au2)); zr_r <= 34'(signed'(ar2));
      fu_r <= fu; fr_r <= fr;
      u_r[0] <= q_w[DS];
      for (int i = 1; i <= NS + NMath; i++) u_r[i] <= u_r[i-1];
    end
  end

  // CORDIC chains for u and rotation
  logic signed [33:0] xu [NS+1], yu [NS+1], zu [NS+1];
  logic signed [33:0] xr [NS+1], yr [NS+1], zr [NS+1];
  assign xu[0] = CordicGainQ30; assign yu[0] = '0; assign zu[0] = zu_r;
  assign xr[0] = CordicGainQ30; assign yr[0] = '0; assign zr[0] = zr_r;

  for (genvar g = 0; g < NS; g++) begin : g_cor
    eop_cordic_cell #(.K(g)) u_cu (
      .clk(clk), .adv(adv), .x_i(xu[g]), .y_i(yu[g]), .z_i(zu[g]),
      .x_o(xu[g+1]), .y_o(yu[g+1]), .z_o(zu[g+1])
    );
    eop_cordic_cell #(.K(g)) u_cr (
      .clk(clk), .adv(adv), .x_i(xr[g]), .y_i(yr[g]), .z_i(zr[g]),
      .x_o(xr[g+1]), .y_o(yr[g+1]), .z_o(zr[g+1])
    );
  end

  // flip flags ride alongside the CORDIC cells
  logic [NS-1:0] flu_r, flr_r;
  always_ff @(posedge clk) begin
    if (adv) begin
      flu_r <= {flu_r[NS-2:0], fu_r};
      flr_r <= {flr_r[NS-2:0], fr_r};
    end
  end

  // math stage 1: apply flips
  logic signed [33:0] cu_r, su_r, cr_r, sr_r;
  always_ff @(posedge clk) begin
    if (adv) begin
      cu_r <= flu_r[NS-1] ? -xu[NS] : xu[NS];
      su_r <= flu_r[NS-1] ? -yu[NS] : yu[NS];
      cr_r <= flr_r[NS-1] ? -xr[NS] : xr[NS];
      sr_r <= flr_r[NS-1] ? -yr[NS] : yr[NS];
    end
  end

  // math stage 2: trig products
  logic signed [63:0] p1_r, p2_r, p3_r, p4_r;
  always_ff @(posedge clk) begin
    if (adv) begin
      p1_r <= 64'(cu_r) * 64'(cr_r);
      p2_r <= 64'(su_r) * 64'(sr_r);
      p3_r <= 64'(cu_r) * 64'(sr_r);
      p4_r <= 64'(su_r) * 64'(cr_r);
    end
  end

  // math stage 3: axis scaling
  logic signed [63:0] m1_r, m2_r, m3_r, m4_r;
  logic signed [63:0] majs, mins;
  assign majs = 64'(signed'({1'b0, maj_r}));
  assign mins = 64'(signed'({1'b0, min_r}));
  always_ff @(posedge clk) begin
    if (adv) begin
      m1_r <= majs * 64'(rnd_q30(p1_r));
      m2_r <= mins * 64'(rnd_q30(p2_r));
      m3_r <= majs * 64'(rnd_q30(p3_r));
      m4_r <= mins * 64'(rnd_q30(p4_r));
    end
  end

  // math stage 4: center sums and saturation
  logic signed [31:0] ca, cb, cc;
  always_comb begin
    case (pl_r)
      PLANE_YZ: begin ca = cy_r; cb = cz_r; cc = cx_r; end
      PLANE_XZ: begin ca = cx_r; cb = cz_r; cc = cy_r; end
      default:  begin ca = cx_r; cb = cy_r; cc = cz_r; end
    endcase
  end
  logic signed [31:0] pa_r, pb_r, pc_r;
  always_ff @(posedge clk) begin
    if (adv) begin
      pa_r <= sat32(36'(ca) + 36'(rnd_q30(m1_r)) - 36'(rnd_q30(m2_r)));
      pb_r <= sat32(36'(cb) + 36'(rnd_q30(m3_r)) + 36'(rnd_q30(m4_r)));
      pc_r <= cc;
    end
  end

  // math stage 5: output register with plane placement
  logic [1:0]  side_o;
  logic [16:0] u_o;
  assign side_o = side_r[Depth-1];
  assign u_o = u_r[NS+NMath-1];
  assign out_valid = vld_r[Depth-1];
  always_ff @(posedge clk) begin
    if (adv) begin
      out_is_last  <= side_r[Depth-2][0] & side_r[Depth-2][1];
      out_in_range <= side_r[Depth-2][1];
      if (!side_r[Depth-2][1]) begin
        out_pos_x <= '0; out_pos_y <= '0; out_pos_z <= '0;
        out_tex_s <= '0; out_tex_t <= '0;
      end else begin
        case (pl_r)
          PLANE_YZ: begin
            out_pos_x <= pc_r; out_pos_y <= pa_r; out_pos_z <= pb_r;
            out_tex_s <= '0; out_tex_t <= u_o;
          end
          PLANE_XZ: begin
            out_pos_x <= pa_r; out_pos_y <= pc_r; out_pos_z <= pb_r;
            out_tex_s <= u_o; out_tex_t <= '0;
          end
          default: begin
            out_pos_x <= pa_r; out_pos_y <= pb_r; out_pos_z <= pc_r;
            out_tex_s <= u_o; out_tex_t <= '0;
          end
        endcase
      end
    end
  end

  // unused tail of sideband and u delay
  logic unused_ok;
  assign unused_ok = ^{side_o, u_r[NS+NMath]};

  // checks
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_pos_x))
    else $error("output changed while stalled");
  a_last_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_is_last |-> out_in_range)
    else $error("last point out of range");
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready == (!out_valid || out_ready))
    else $error("ready mismatch");
endmodule
`default_nettype wire

FILE: rtl/core/eop_div_cell.sv
// One restoring-division cell: produces one quotient bit of idx*65536/seg.
// Depends on eop_pkg.
`default_nettype none
module eop_div_cell
  import eop_pkg::*;
#(
  parameter int NumW = 29,
  parameter int DenW = 13,
  parameter int BitPos = 0
) (
  input  wire logic            clk,
  input  wire logic            adv,
  input  wire logic [NumW-1:0] rem_i,
  input  wire logic [DenW-1:0] den_i,
  input  wire logic [16:0]     q_i,
  output logic [NumW-1:0]      rem_o,
  output logic [DenW-1:0]      den_o,
  output logic [16:0]          q_o
);
  logic [NumW:0] trial;
  logic          take;
  logic [NumW-1:0] rem_nxt;
  logic [16:0]   q_nxt;

  // compare remainder against den shifted to this bit
  always_comb begin
    trial = {1'b0, rem_i} - ({{(NumW+1-DenW){1'b0}}, den_i} << BitPos);
    take  = ~trial[NumW];
    rem_nxt = take ? trial[NumW-1:0] : rem_i;
    q_nxt = q_i;
    q_nxt[BitPos] = take;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rem_o <= rem_nxt;
      den_o <= den_i;
      q_o   <= q_nxt;
    end
  end
endmodule
`default_nettype wire

FILE: rtl/core/eop_cordic_cell.sv
// One CORDIC rotation cell, stage K, carrying one rotation vector.
// Depends on eop_pkg.
`default_nettype none
module eop_cordic_cell
  import eop_pkg::*;
#(
  parameter int K = 0
) (
  input  wire logic               clk,
  input  wire logic               adv,
  input  wire logic signed [33:0] x_i,
  input  wire logic signed [33:0] y_i,
  input  wire logic signed [33:0] z_i,
  output logic signed [33:0]      x_o,
  output logic signed [33:0]      y_o,
  output logic signed [33:0]      z_o
);
  logic signed [33:0] dx, dy, at;
  assign dx = y_i >>> K;
  assign dy = x_i >>> K;
  assign at = atan_turn(5'(K));

  always_ff @(posedge clk) begin
    if (adv) begin
      if (!z_i[33]) begin
        x_o <= x_i - dx; y_o <= y_i + dy; z_o <= z_i - at;
      end else begin
        x_o <= x_i + dx; y_o <= y_i - dy; z_o <= z_i + at;
      end
    end
  end
endmodule
`default_nettype wire

FILE: tb/ellipse_outline_points_core_tb.sv
// Testbench for ellipse_outline_points_core: directed cases plus random points,
// checked against a behavioral point predictor. Depends on eop_pkg and the core RTL.
`timescale 1ns / 1ps
module ellipse_outline_points_core_tb;
  import eop_pkg::*;

  localparam int MaxSeg = 4096;
  localparam int Stages = 16;
  localparam int Latency = Stages + 23;

  typedef struct packed {
    logic [31:0] pos_x;
    logic [31:0] pos_y;
    logic [31:0] pos_z;
    logic [16:0] tex_s;
    logic [16:0] tex_t;
    logic        is_last;
    logic        in_range;
  } point_t;

  typedef struct {
    logic [12:0] idx;
    bit          known;
    point_t      pt;
  } row_t;

  logic clk = 0;
  logic rst_n = 0;
  logic in_valid = 0;
  logic [12:0] in_point_index = '0;
  logic out_ready = 0;
  logic cfg_valid = 0;
  logic [2:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;
  logic in_ready, out_valid, cfg_ready;
  logic [31:0] out_pos_x, out_pos_y, out_pos_z;
  logic [16:0] out_tex_s, out_tex_t;
  logic out_is_last, out_in_range;

  always #10 clk = ~clk;

  ellipse_outline_points_core DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_point_index(in_point_index),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_pos_x(out_pos_x), .out_pos_y(out_pos_y), .out_pos_z(out_pos_z),
    .out_tex_s(out_tex_s), .out_tex_t(out_tex_t),
    .out_is_last(out_is_last), .out_in_range(out_in_range),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // Shadow copy of the configuration registers
  logic signed [63:0] ctr_x, ctr_y, ctr_z, len_major, len_minor;
  logic [15:0] rot_ang;
  logic [1:0]  plane;
  logic [12:0] seg_cnt;

  point_t expected_points[$];
  int errors = 0;
  bit no_idle = 0;
  bit hold_sink = 0;

  function automatic logic signed [63:0] round_q30(input logic signed [63:0] p);
    return (p + 64'sd536870912) >>> 30;
  endfunction

  function automatic logic signed [63:0] sat_word(input logic signed [63:0] v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // Rotation-mode CORDIC on a 1/65536-turn angle, with half-turn reduction
  function automatic void cos_sin(input logic [15:0] ang, output logic signed [63:0] c,
                                  output logic signed [63:0] s);
    logic [31:0] a;
    bit flip;
    logic signed [63:0] x, y, z, dx, dy;
    a = {ang, 16'h0};
    flip = 0;
    x = 64'sd652032874;
    y = 0;
    if (a >= 32'h4000_0000 && a < 32'hC000_0000) begin
      a = a - 32'h8000_0000;
      flip = 1;
    end
    z = {{32{a[31]}}, a};
    for (int k = 0; k < Stages; k++) begin
      dx = y >>> k;
      dy = x >>> k;
      if (z >= 0) begin
        x = x - dx; y = y + dy; z = z - atan_turn(k[4:0]);
      end else begin
        x = x + dx; y = y - dy; z = z + atan_turn(k[4:0]);
      end
    end
    c = flip ? -x : x;
    s = flip ? -y : y;
  endfunction

  function automatic point_t outline_point(input logic [12:0] idx);
    point_t r;
    logic [31:0] seg, u;
    logic signed [63:0] cu, su, cr, sr, ca, cb, cc, pa, pb;
    r = '0;
    seg = seg_cnt;
    if (seg == 0) seg = 1;
    if (seg > MaxSeg) seg = MaxSeg;
    if (idx > seg) return r;
    u = (idx * 32'd65536) / seg;
    cos_sin(u[15:0], cu, su);
    cos_sin(rot_ang, cr, sr);
    if (plane == PLANE_YZ) begin
      ca = ctr_y; cb = ctr_z; cc = ctr_x;
    end else if (plane == PLANE_XZ) begin
      ca = ctr_x; cb = ctr_z; cc = ctr_y;
    end else begin
      ca = ctr_x; cb = ctr_y; cc = ctr_z;
    end
    pa = sat_word(ca + round_q30(len_major * round_q30(cu * cr))
                     - round_q30(len_minor * round_q30(su * sr)));
    pb = sat_word(cb + round_q30(len_major * round_q30(cu * sr))
                     + round_q30(len_minor * round_q30(su * cr)));
    if (plane == PLANE_YZ) begin
      r.pos_x = cc[31:0]; r.pos_y = pa[31:0]; r.pos_z = pb[31:0];
      r.tex_t = u[16:0];
    end else if (plane == PLANE_XZ) begin
      r.pos_x = pa[31:0]; r.pos_y = cc[31:0]; r.pos_z = pb[31:0];
      r.tex_s = u[16:0];
    end else begin
      r.pos_x = pa[31:0]; r.pos_y = pb[31:0]; r.pos_z = cc[31:0];
      r.tex_s = u[16:0];
    end
    r.is_last = (idx == seg);
    r.in_range = 1;
    return r;
  endfunction

  task automatic wait_cycles(input int n);
    repeat (n) @(posedge clk);
  endtask

  // Register write transaction, mirrored into the shadow copy
  task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 0;
    case (idx)
      CFG_CENTER_X:  ctr_x = $signed(val);
      CFG_CENTER_Y:  ctr_y = $signed(val);
      CFG_CENTER_Z:  ctr_z = $signed(val);
      CFG_MAJOR_LEN: len_major = {33'b0, val[30:0]};
      CFG_MINOR_LEN: len_minor = {33'b0, val[30:0]};
      CFG_ROTATION:  rot_ang = val[15:0];
      CFG_PLANE_SEL: plane = val[1:0];
      CFG_SEGMENTS:  seg_cnt = val[12:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic drain();
    while (expected_points.size() != 0) @(posedge clk);
    wait_cycles(Latency + 4);
  endtask

  task automatic set_all(input logic [31:0] x, input logic [31:0] y, input logic [31:0] z,
                         input logic [31:0] ma, input logic [31:0] mi,
                         input logic [31:0] ro, input logic [31:0] pl,
                         input logic [31:0] sg);
    write_reg(CFG_CENTER_X, x);
    write_reg(CFG_CENTER_Y, y);
    write_reg(CFG_CENTER_Z, z);
    write_reg(CFG_MAJOR_LEN, ma);
    write_reg(CFG_MINOR_LEN, mi);
    write_reg(CFG_ROTATION, ro);
    write_reg(CFG_PLANE_SEL, pl);
    write_reg(CFG_SEGMENTS, sg);
  endtask

  // One input transaction; valid stays high across back-to-back items
  task automatic send_point(input logic [12:0] idx, input bit known, input point_t pt);
    int gap;
    if (!no_idle && $urandom_range(0, 5) == 0) begin
      in_valid <= 0;
      gap = $urandom_range(1, 10);
      wait_cycles(gap);
    end
    in_valid <= 1;
    in_point_index <= idx;
    do @(posedge clk); while (!in_ready);
    expected_points.push_back(known ? pt : outline_point(idx));
  endtask

  function automatic logic [12:0] pick_index();
    int s;
    s = (seg_cnt == 0) ? 1 : (seg_cnt > MaxSeg ? MaxSeg : seg_cnt);
    if ($urandom_range(0, 9) == 0) return 13'($urandom);
    if ($urandom_range(0, 9) == 0) return 13'(s);
    return 13'($urandom_range(0, s));
  endfunction

  // Sink: random backpressure, optional long hold
  initial begin
    int n;
    forever begin
      @(posedge clk);
      if (hold_sink) begin
        out_ready <= 0;
        n = 0;
        while (n < 200) begin
          @(posedge clk);
          n++;
        end
        hold_sink = 0;
      end
      if (!no_idle && $urandom_range(0, 7) == 0) begin
        out_ready <= 0;
        n = $urandom_range(1, 10);
        wait_cycles(n);
      end
      out_ready <= 1;
    end
  end

  // Result checker
  always @(posedge clk) begin
    point_t exp_pt;
    if (rst_n && out_valid && out_ready) begin
      if (expected_points.size() == 0) begin
        $error("unexpected result transaction");
        errors++;
      end else begin
        exp_pt = expected_points.pop_front();
        if (out_pos_x !== exp_pt.pos_x) begin
          $error("pos_x exp %h got %h", exp_pt.pos_x, out_pos_x); errors++;
        end
        if (out_pos_y !== exp_pt.pos_y) begin
          $error("pos_y exp %h got %h", exp_pt.pos_y, out_pos_y); errors++;
        end
        if (out_pos_z !== exp_pt.pos_z) begin
          $error("pos_z exp %h got %h", exp_pt.pos_z, out_pos_z); errors++;
        end
        if (out_tex_s !== exp_pt.tex_s) begin
          $error("tex_s exp %h got %h", exp_pt.tex_s, out_tex_s); errors++;
        end
        if (out_tex_t !== exp_pt.tex_t) begin
          $error("tex_t exp %h got %h", exp_pt.tex_t, out_tex_t); errors++;
        end
        if (out_is_last !== exp_pt.is_last) begin
          $error("is_last exp %b got %b", exp_pt.is_last, out_is_last); errors++;
        end
        if (out_in_range !== exp_pt.in_range) begin
          $error("in_range exp %b got %b", exp_pt.in_range, out_in_range); errors++;
        end
      end
    end
  end

  // Run limit
  initial begin
    #40ms;
    $display("ellipse_outline_points_core_tb failed");
    $finish;
  end

  // Directed table: rows with known=1 carry a result read off directly
  row_t rows[$];
  point_t pz;

  initial begin
    point_t p;
    ctr_x = 0; ctr_y = 0; ctr_z = 0; len_major = 0; len_minor = 0;
    rot_ang = 0; plane = PLANE_XY; seg_cnt = 1;
    wait_cycles(9);
    rst_n <= 1;
    @(posedge clk);

    // After reset: segments 1, zero axes, so index 0 is origin with u 0
    pz = '0;
    p = pz; p.in_range = 1;
    rows.push_back('{13'd0, 1, p});
    p = pz; p.in_range = 1; p.is_last = 1; p.tex_s = 17'd65536;
    rows.push_back('{13'd1, 1, p});
    rows.push_back('{13'd2, 1, pz});
    rows.push_back('{13'h1FFF, 1, pz});
    foreach (rows[i]) send_point(rows[i].idx, rows[i].known, rows[i].pt);
    in_valid <= 0;
    drain();

    // Extremes: saturating centers and maximum axes, each plane
    for (int pl = 0; pl < 4; pl++) begin
      set_all(32'h7FFF_FFFF, 32'h8000_0000, 32'h0001_0000, 32'h7FFF_FFFF,
              32'h7FFF_FFFF, $urandom_range(0, 65535), pl, 8);
      for (int i = 0; i <= 9; i++) send_point(i, 0, pz);
      in_valid <= 0;
      drain();
    end
    // Segment count zero and above the maximum
    set_all(0, 32'h0010_0000, 32'hFFF0_0000, 32'h0030_0000, 32'h0010_0000, 16'hFFFF,
            PLANE_XY, 0);
    for (int i = 0; i <= 2; i++) send_point(i, 0, pz);
    in_valid <= 0;
    drain();
    write_reg(CFG_SEGMENTS, 32'h1FFF);
    send_point(4096, 0, pz);
    send_point(4097, 0, pz);
    send_point(13'h1FFF, 1, pz);
    send_point($urandom_range(0, 4095), 0, pz);
    in_valid <= 0;
    drain();

    // Random phases: long sink hold in the first, input pause in the second, no idles in the last two
    for (int ph = 0; ph < 12; ph++) begin
      int sg;
      sg = (ph % 4 == 0) ? 4096 : $urandom_range(1, 64);
      set_all($urandom, $urandom, $urandom,
              (ph % 3 == 0) ? $urandom : $urandom_range(0, 32'h0100_0000),
              (ph % 3 == 0) ? $urandom : $urandom_range(0, 32'h0100_0000),
              $urandom, $urandom_range(0, 3), sg);
      if (ph == 0) hold_sink = 1;
      if (ph >= 10) no_idle = 1;
      for (int i = 0; i < 135; i++) begin
        send_point(pick_index(), 0, pz);
        if (ph == 1 && i == 60) begin
          in_valid <= 0;
          while (expected_points.size() != 0) @(posedge clk);
        end
      end
      in_valid <= 0;
      drain();
    end

    if (errors == 0) begin
      $display("ellipse_outline_points_core_tb passed");
    end else begin
      $display("ellipse_outline_points_core_tb failed");
    end
    $finish;
  end

endmodule
